// ===== rtl/ats_pkg.sv =====
`default_nettype none

package ats_pkg;

    // Table geometry and fixed-point format.
    localparam int MAX_ENTRIES    = 1024;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int SCALED_W       = IDX_W + PROB_W;
    localparam int SUM_W          = 42;
    localparam int WEIGHT_W       = 32;
    localparam int FRAC_W         = 32;
    localparam int PA_W           = PROB_W + IDX_W;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    // Action codes carried on the input tuser.
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_SAMPLE = 2'd3;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_FALLBACK = 2'd2;

    // Register index on the configuration port.
    localparam logic REG_ENTRY_COUNT = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/alias_table_sampler.sv =====
`default_nettype none

// Channel  | Dir | Signals                              | Contents
// ---------+-----+--------------------------------------+-----------------------------------
// input    | in  | s_tvalid s_tready s_tdata s_tuser    | action, index, weight, fraction
// output   | out | m_tvalid m_tready m_tdata m_tuser    | status, index, probability, alias
// config   | in  | psel penable pwrite paddr pwdata ... | entry_count at byte address 0
//
// One word is handled at a time. A weight write answers in the cycle after acceptance, a
// table read passes through ST_RESP and a sample through ST_SREAD and ST_RESP before the
// result word; each memory port gives one access a cycle with a registered read.
// After reset all 1024 probability/alias slots are swept to zero, during which no input
// word is taken. A build clears that memory, sums the weights (and on the uniform fallback
// fills each weight with one), scales every entry with the serial divider, pairs small and
// large entries, then writes each leftover entry. A stalled result blocks new input.

module alias_table_sampler
    import ats_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // [9:0] entry_index, [41:10] weight_value,
                                       // [73:42] uniform_fraction, [79:74] zero
    input  wire logic [1:0]  s_tuser,  // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // [9:0] chosen_index, [26:10] probability,
                                       // [36:27] alias_index, [39:37] zero
    output logic [1:0]       m_tuser,  // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [4:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_SREAD,
        ST_RESP,
        ST_CLR,
        ST_SUM,
        ST_FILL,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_SC_WR,
        ST_P_QRD,
        ST_P_SRD,
        ST_P_LRD,
        ST_P_UPD,
        ST_D_RD,
        ST_D_WR
    } state_t;

    // Control and sequencing registers.
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [1:0]            bstat_reg, bstat_next;
    logic                  sample_reg, sample_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PROB_FRAC_BITS-1:0] t_reg, t_next;
    logic [SUM_W-1:0]      r_reg, r_next;
    logic [SCALED_W-1:0]   dvd_reg, dvd_next;
    logic [SCALED_W-1:0]   q_reg, q_next;
    logic [4:0]            step_reg, step_next;
    logic [IDX_W-1:0]      sh_reg, sh_next, st_reg, st_next;
    logic [IDX_W-1:0]      lh_reg, lh_next, lt_reg, lt_next;
    logic [CNT_W-1:0]      sc_reg, sc_next, lc_reg, lc_next;
    logic [IDX_W-1:0]      s_reg, s_next, l_reg, l_next;
    logic [SCALED_W-1:0]   ps_reg, ps_next;
    logic                  dlarge_reg, dlarge_next;
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            o_status_reg, o_status_next;
    logic [IDX_W-1:0]      o_chosen_reg, o_chosen_next;
    logic [PROB_W-1:0]     o_prob_reg, o_prob_next;
    logic [IDX_W-1:0]      o_alias_reg, o_alias_next;

    // Memory ports: one write and one registered read per memory.
    logic [WEIGHT_W-1:0]   w_mem [MAX_ENTRIES];
    logic                  w_we;
    logic [IDX_W-1:0]      w_wa, w_ra;
    logic [WEIGHT_W-1:0]   w_wd, w_rd;

    logic [SCALED_W-1:0]   sw_mem [MAX_ENTRIES];
    logic                  sw_we;
    logic [IDX_W-1:0]      sw_wa, sw_ra;
    logic [SCALED_W-1:0]   sw_wd, sw_rd;

    logic [PA_W-1:0]       pa_mem [MAX_ENTRIES];
    logic                  pa_we;
    logic [IDX_W-1:0]      pa_wa, pa_ra;
    logic [PA_W-1:0]       pa_wd, pa_rd;

    logic [IDX_W-1:0]      sq_mem [MAX_ENTRIES];
    logic                  sq_we;
    logic [IDX_W-1:0]      sq_wd, sq_rd;

    logic [IDX_W-1:0]      lq_mem [MAX_ENTRIES];
    logic                  lq_we;
    logic [IDX_W-1:0]      lq_wd, lq_rd;

    // Datapath helpers.
    logic                  accept;
    logic [CNT_W-1:0]      n_act;
    logic [IDX_W-1:0]      in_idx;
    logic [WEIGHT_W-1:0]   in_weight;
    logic [FRAC_W-1:0]     in_frac;
    logic [SUM_W-1:0]      w_clip;
    logic [FRAC_W+CNT_W-1:0] x_prod;
    logic [SUM_W-1:0]      num_prod;
    logic [SUM_W:0]        trial;
    logic                  ge;
    logic [SUM_W:0]        trial_sub;
    logic [SCALED_W:0]     upd_sum;
    logic [SCALED_W-1:0]   upd_val;
    logic [PROB_W-1:0]     rd_prob;
    logic [IDX_W-1:0]      rd_alias;

    assign in_idx    = s_tdata[9:0];
    assign in_weight = s_tdata[41:10];
    assign in_frac   = s_tdata[73:42];

    // The active count saturates at the table size.
    assign n_act = (entry_count_reg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                           : entry_count_reg;

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {3'b000, o_alias_reg, o_prob_reg, o_chosen_reg};

    // Configuration port: always ready, one register at byte address zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {21'd0, entry_count_reg} : 32'd0;

    // Negative weights count as zero.
    assign w_clip   = w_rd[WEIGHT_W-1] ? '0 : SUM_W'(w_rd[WEIGHT_W-2:0]);
    assign x_prod   = in_frac * n_act;
    assign num_prod = SUM_W'(w_rd[WEIGHT_W-1] ? 31'd0 : w_rd[WEIGHT_W-2:0]) * SUM_W'(n_act);

    // One restoring division step per cycle.
    assign trial     = {r_reg, dvd_reg[SCALED_W-1]};
    assign trial_sub = trial - {1'b0, sum_reg};
    assign ge        = (trial >= {1'b0, sum_reg});

    // Large entry keeps what the small entry did not use.
    assign upd_sum = {1'b0, sw_rd} + {1'b0, ps_reg} - (SCALED_W+1)'(PROB_ONE);
    assign upd_val = upd_sum[SCALED_W-1:0];

    assign rd_prob  = pa_rd[PA_W-1:IDX_W];
    assign rd_alias = pa_rd[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        sum_next         = sum_reg;
        bstat_next       = bstat_reg;
        sample_next      = sample_reg;
        idx_next         = idx_reg;
        t_next           = t_reg;
        r_next           = r_reg;
        dvd_next         = dvd_reg;
        q_next           = q_reg;
        step_next        = step_reg;
        sh_next          = sh_reg;
        st_next          = st_reg;
        lh_next          = lh_reg;
        lt_next          = lt_reg;
        sc_next          = sc_reg;
        lc_next          = lc_reg;
        s_next           = s_reg;
        l_next           = l_reg;
        ps_next          = ps_reg;
        dlarge_next      = dlarge_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        o_status_next    = o_status_reg;
        o_chosen_next    = o_chosen_reg;
        o_prob_next      = o_prob_reg;
        o_alias_next     = o_alias_reg;

        w_we  = 1'b0;
        w_wa  = in_idx;
        w_wd  = in_weight;
        w_ra  = cnt_reg[IDX_W-1:0];
        sw_we = 1'b0;
        sw_wa = cnt_reg[IDX_W-1:0];
        sw_wd = q_reg;
        sw_ra = sq_rd;
        pa_we = 1'b0;
        pa_wa = cnt_reg[IDX_W-1:0];
        pa_wd = '0;
        pa_ra = in_idx;
        sq_we = 1'b0;
        sq_wd = cnt_reg[IDX_W-1:0];
        lq_we = 1'b0;
        lq_wd = cnt_reg[IDX_W-1:0];

        if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT))
        begin
            entry_count_next = pwdata[CNT_W-1:0];
        end

        unique case (state_reg)
            ST_INIT_CLR, ST_CLR:
            begin
                pa_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg[IDX_W-1:0])
                begin
                    cnt_next = '0;
                    if (state_reg == ST_INIT_CLR)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (n_act == '0)
                    begin
                        m_valid_next  = 1'b1;
                        o_status_next = STATUS_EMPTY;
                        o_chosen_next = '0;
                        o_prob_next   = '0;
                        o_alias_next  = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        sum_next   = '0;
                        bstat_next = STATUS_OK;
                        state_next = ST_SUM;
                    end
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        ACT_WRITE:
                        begin
                            w_we          = 1'b1;
                            m_valid_next  = 1'b1;
                            o_status_next = STATUS_OK;
                            o_chosen_next = in_idx;
                            o_prob_next   = '0;
                            o_alias_next  = '0;
                        end
                        ACT_BUILD:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLR;
                        end
                        ACT_READ:
                        begin
                            sample_next = 1'b0;
                            idx_next    = in_idx;
                            state_next  = ST_RESP;
                        end
                        ACT_SAMPLE:
                        begin
                            if (n_act == '0)
                            begin
                                m_valid_next  = 1'b1;
                                o_status_next = STATUS_EMPTY;
                                o_chosen_next = '0;
                                o_prob_next   = '0;
                                o_alias_next  = '0;
                            end
                            else
                            begin
                                sample_next = 1'b1;
                                idx_next    = x_prod[FRAC_W+IDX_W-1:FRAC_W];
                                t_next      = x_prod[FRAC_W-1:FRAC_W-PROB_FRAC_BITS];
                                state_next  = ST_SREAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SREAD:
            begin
                pa_ra      = idx_reg;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                m_valid_next  = 1'b1;
                o_status_next = STATUS_OK;
                o_prob_next   = rd_prob;
                o_alias_next  = rd_alias;
                if (sample_reg && ({1'b0, t_reg} >= rd_prob))
                begin
                    o_chosen_next = rd_alias;
                end
                else
                begin
                    o_chosen_next = idx_reg;
                end
                state_next = ST_IDLE;
            end

            ST_SUM:
            begin
                if (cnt_reg < n_act)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + w_clip;
                end
                else if (cnt_reg == n_act)
                begin
                    cnt_next = '0;
                    if (sum_reg == '0)
                    begin
                        sum_next   = SUM_W'(n_act);
                        bstat_next = STATUS_FALLBACK;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_SC_RD;
                    end
                end
            end

            ST_FILL:
            begin
                w_wa = cnt_reg[IDX_W-1:0];
                w_wd = WEIGHT_W'(1);
                if (cnt_reg < n_act)
                begin
                    w_we     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SC_RD;
                end
            end

            ST_SC_RD:
            begin
                state_next = ST_SC_MUL;
            end

            ST_SC_MUL:
            begin
                // Quotient fits in SCALED_W bits, so the top part starts below the sum.
                r_next     = SUM_W'(num_prod[SUM_W-1:IDX_W+1]);
                dvd_next   = {num_prod[IDX_W:0], PROB_FRAC_BITS'(0)};
                q_next     = '0;
                step_next  = '0;
                state_next = ST_SC_DIV;
            end

            ST_SC_DIV:
            begin
                r_next    = ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
                dvd_next  = {dvd_reg[SCALED_W-2:0], 1'b0};
                q_next    = {q_reg[SCALED_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(SCALED_W - 1))
                begin
                    state_next = ST_SC_WR;
                end
            end

            ST_SC_WR:
            begin
                sw_we = 1'b1;
                if (q_reg < SCALED_W'(PROB_ONE))
                begin
                    sq_we   = 1'b1;
                    st_next = st_reg + 1'b1;
                    sc_next = sc_reg + 1'b1;
                end
                else
                begin
                    lq_we   = 1'b1;
                    lt_next = lt_reg + 1'b1;
                    lc_next = lc_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == n_act)
                begin
                    state_next = ST_P_QRD;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end

            ST_P_QRD:
            begin
                if ((sc_reg != '0) && (lc_reg != '0))
                begin
                    sh_next    = sh_reg + 1'b1;
                    lh_next    = lh_reg + 1'b1;
                    sc_next    = sc_reg - 1'b1;
                    lc_next    = lc_reg - 1'b1;
                    state_next = ST_P_SRD;
                end
                else
                begin
                    state_next = ST_D_RD;
                end
            end

            ST_P_SRD:
            begin
                s_next     = sq_rd;
                l_next     = lq_rd;
                sw_ra      = sq_rd;
                state_next = ST_P_LRD;
            end

            ST_P_LRD:
            begin
                ps_next    = sw_rd;
                sw_ra      = l_reg;
                state_next = ST_P_UPD;
            end

            ST_P_UPD:
            begin
                pa_we = 1'b1;
                pa_wa = s_reg;
                pa_wd = {ps_reg[PROB_W-1:0], l_reg};
                sw_we = 1'b1;
                sw_wa = l_reg;
                sw_wd = upd_val;
                sq_wd = l_reg;
                lq_wd = l_reg;
                if (upd_val < SCALED_W'(PROB_ONE))
                begin
                    sq_we   = 1'b1;
                    st_next = st_reg + 1'b1;
                    sc_next = sc_reg + 1'b1;
                end
                else
                begin
                    lq_we   = 1'b1;
                    lt_next = lt_reg + 1'b1;
                    lc_next = lc_reg + 1'b1;
                end
                state_next = ST_P_QRD;
            end

            ST_D_RD:
            begin
                if (lc_reg != '0)
                begin
                    dlarge_next = 1'b1;
                    lh_next     = lh_reg + 1'b1;
                    lc_next     = lc_reg - 1'b1;
                    state_next  = ST_D_WR;
                end
                else if (sc_reg != '0)
                begin
                    dlarge_next = 1'b0;
                    sh_next     = sh_reg + 1'b1;
                    sc_next     = sc_reg - 1'b1;
                    state_next  = ST_D_WR;
                end
                else
                begin
                    m_valid_next  = 1'b1;
                    o_status_next = bstat_reg;
                    o_chosen_next = '0;
                    o_prob_next   = '0;
                    o_alias_next  = '0;
                    state_next    = ST_IDLE;
                end
            end

            ST_D_WR:
            begin
                // A leftover entry keeps a cleared alias and takes full probability.
                pa_we      = 1'b1;
                pa_wa      = dlarge_reg ? lq_rd : sq_rd;
                pa_wd      = {PROB_ONE, IDX_W'(0)};
                state_next = ST_D_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT_CLR;
            entry_count_reg <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            sum_reg         <= '0;
            bstat_reg       <= STATUS_OK;
            sh_reg          <= '0;
            st_reg          <= '0;
            lh_reg          <= '0;
            lt_reg          <= '0;
            sc_reg          <= '0;
            lc_reg          <= '0;
            dlarge_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
            sum_reg         <= sum_next;
            bstat_reg       <= bstat_next;
            sh_reg          <= sh_next;
            st_reg          <= st_next;
            lh_reg          <= lh_next;
            lt_reg          <= lt_next;
            sc_reg          <= sc_next;
            lc_reg          <= lc_next;
            dlarge_reg      <= dlarge_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        idx_reg      <= idx_next;
        t_reg        <= t_next;
        r_reg        <= r_next;
        dvd_reg      <= dvd_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        s_reg        <= s_next;
        l_reg        <= l_next;
        ps_reg       <= ps_next;
        o_status_reg <= o_status_next;
        o_chosen_reg <= o_chosen_next;
        o_prob_reg   <= o_prob_next;
        o_alias_reg  <= o_alias_next;
    end

    // Weight store.
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_wa] <= w_wd;
        end
        w_rd <= w_mem[w_ra];
    end

    // Scaled weights.
    always_ff @(posedge clk)
    begin
        if (sw_we)
        begin
            sw_mem[sw_wa] <= sw_wd;
        end
        sw_rd <= sw_mem[sw_ra];
    end

    // Probability and alias, one word per slot.
    always_ff @(posedge clk)
    begin
        if (pa_we)
        begin
            pa_mem[pa_wa] <= pa_wd;
        end
        pa_rd <= pa_mem[pa_ra];
    end

    // Small and large index queues, pushed at the tail and read at the head.
    always_ff @(posedge clk)
    begin
        if (sq_we)
        begin
            sq_mem[st_reg] <= sq_wd;
        end
        sq_rd <= sq_mem[sh_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lq_we)
        begin
            lq_mem[lt_reg] <= lq_wd;
        end
        lq_rd <= lq_mem[lh_reg];
    end

endmodule

`default_nettype wire
